// ===== src/gatm_pkg.sv =====
// shared types and codes for the goal action transition matcher
// request and result payload structs, action and status codes
// no dependencies
package gatm_pkg;

	// action codes of a request
	localparam logic [2:0] ACT_CLEAR    = 3'd0;
	localparam logic [2:0] ACT_SET_PRE  = 3'd1;
	localparam logic [2:0] ACT_SET_POST = 3'd2;
	localparam logic [2:0] ACT_SET_COST = 3'd3;
	localparam logic [2:0] ACT_EXPAND   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_WRITE_DONE = 2'd0;
	localparam logic [1:0] ST_FOUND      = 2'd1;
	localparam logic [1:0] ST_NONE       = 2'd2;
	localparam logic [1:0] ST_REJECTED   = 2'd3;

	// upper bound on results of one expand
	localparam int MAX_RESULTS = 64;

	typedef struct packed {
		logic [2:0]  action;
		logic [5:0]  entry_index;
		logic [5:0]  atom_index;
		logic        atom_value;
		logic [15:0] new_cost;
		logic [63:0] state_values;
		logic [63:0] state_dont_care;
		logic [6:0]  result_limit;
	} gatm_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  matched_entry;
		logic [63:0] next_values;
		logic [63:0] next_dont_care;
		logic [15:0] action_cost;
		logic        last;
	} gatm_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic       capture;
		logic       clear_tab;
		logic       rd_entry;
		logic       wr_entry;
		logic       scan_start;
		logic       scan_run;
		logic       emit_final;
		logic       emit_code;
		logic [1:0] code;
	} gatm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op_clear;
		logic op_write;
		logic op_expand;
		logic wr_ok;
		logic out_free;
		logic scan_done;
	} gatm_stat_t;

endpackage

// ===== src/gatm_ctrl.sv =====
// controller state machine of the goal action transition matcher
// sequences write, clear and expand requests; depends on gatm_pkg
module gatm_ctrl import gatm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  gatm_stat_t stat,
	output gatm_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_RMW    = 6'b000100,
		S_RESP   = 6'b001000,
		S_SCAN   = 6'b010000,
		S_FLUSH  = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] code_q, code_d;

	always_comb begin
		state_d   = state_q;
		code_d    = code_q;
		cmd       = '0;
		cmd.code  = code_q;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (stat.op_clear) begin
					cmd.clear_tab = 1'b1;
					code_d        = ST_WRITE_DONE;
					state_d       = S_RESP;
				end else if (stat.op_write && stat.wr_ok) begin
					cmd.rd_entry = 1'b1;
					state_d      = S_RMW;
				end else if (stat.op_expand) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					code_d  = ST_REJECTED;
					state_d = S_RESP;
				end
			end
			S_RMW: begin
				cmd.wr_entry = 1'b1;
				code_d       = ST_WRITE_DONE;
				state_d      = S_RESP;
			end
			S_RESP: begin
				cmd.emit_code = stat.out_free;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (stat.scan_done) begin
					state_d = S_FLUSH;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			S_FLUSH: begin
				cmd.emit_final = stat.out_free;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_WRITE_DONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

// ===== src/gatm_datapath.sv =====
// datapath of the goal action transition matcher: action table memory,
// request capture, entry count, scan counters and the result register
// depends on gatm_pkg
module gatm_datapath import gatm_pkg::*; #(
	parameter int NUM_ENTRIES = 64,
	parameter int NUM_ATOMS   = 64,
	parameter int COST_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  gatm_req_t  request,
	input  gatm_cmd_t  cmd,
	output gatm_stat_t stat,
	output logic       res_valid,
	input  logic       res_ready,
	output gatm_rsp_t  result
);

	localparam int IW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CW  = $clog2(NUM_ENTRIES + 1);
	localparam int NA  = NUM_ATOMS;
	localparam int CSW = (COST_BITS < 16) ? COST_BITS : 16;
	localparam logic [15:0] COST_MAX = 16'((1 << CSW) - 1);
	localparam logic [6:0]  NE7      = 7'(NUM_ENTRIES);
	localparam logic [6:0]  NA7      = 7'(NUM_ATOMS);
	localparam logic [6:0]  LIM_MAX  = 7'(MAX_RESULTS);
	// atoms above the table width are never cared about
	localparam logic [63:0] HI_ONES  = ~((64'(1) << NUM_ATOMS) - 64'(1));

	// action table, one row per entry
	logic [NA-1:0]  pre_v_mem   [NUM_ENTRIES];
	logic [NA-1:0]  pre_dc_mem  [NUM_ENTRIES];
	logic [NA-1:0]  post_v_mem  [NUM_ENTRIES];
	logic [NA-1:0]  post_dc_mem [NUM_ENTRIES];
	logic [CSW-1:0] cost_mem    [NUM_ENTRIES];

	logic [NA-1:0]  rd_pre_v_q, rd_pre_dc_q, rd_post_v_q, rd_post_dc_q;
	logic [CSW-1:0] rd_cost_q;

	gatm_req_t      req_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  rd_ptr_q;
	logic [IW-1:0]  chk_idx_q;
	logic           chk_valid_q;
	logic [6:0]     n_q;
	logic [6:0]     lim_q;
	logic           pend_valid_q;
	gatm_rsp_t      pend_q;
	logic           res_valid_q;
	gatm_rsp_t      res_q;

	logic           out_free;
	logic           chk_match;
	logic           stall, adv, take, push_mid, issue, rd_en;
	logic [IW-1:0]  rd_addr, wr_addr;
	logic           create;
	logic [NA-1:0]  atom_bit;
	logic [NA-1:0]  new_pre_v, new_pre_dc, new_post_v, new_post_dc;
	logic [CSW-1:0] new_cost, sat_cost;
	logic [63:0]    keep64;
	logic [6:0]     idx7, cnt7, lim_in;
	gatm_rsp_t      found;
	gatm_rsp_t      res_d;

	assign idx7 = 7'(req_q.entry_index);
	assign cnt7 = 7'(count_q);

	// request decode
	assign stat.op_clear  = (req_q.action == ACT_CLEAR);
	assign stat.op_write  = (req_q.action == ACT_SET_PRE) || (req_q.action == ACT_SET_POST)
		|| (req_q.action == ACT_SET_COST);
	assign stat.op_expand = (req_q.action == ACT_EXPAND);
	assign stat.wr_ok     = ((idx7 < cnt7) || ((idx7 == cnt7) && (cnt7 < NE7)))
		&& ((req_q.action == ACT_SET_COST) || (7'(req_q.atom_index) < NA7));

	assign out_free       = !res_valid_q || res_ready;
	assign stat.out_free  = out_free;
	assign stat.scan_done = (n_q == lim_q) || (!chk_valid_q && (rd_ptr_q == count_q));

	assign lim_in = (request.result_limit > LIM_MAX) ? LIM_MAX : request.result_limit;

	// precondition test against the entry held in the read register
	assign chk_match = ((rd_pre_v_q ^ req_q.state_values[NA-1:0]) & ~rd_pre_dc_q) == '0;
	assign keep64    = 64'(rd_post_dc_q) | HI_ONES;

	always_comb begin
		found                = '0;
		found.status         = ST_FOUND;
		found.matched_entry  = 6'(chk_idx_q);
		found.next_values    = (req_q.state_values & keep64) | (64'(rd_post_v_q) & ~keep64);
		found.next_dont_care = req_q.state_dont_care & keep64;
		found.action_cost    = 16'(rd_cost_q);
		found.last           = 1'b0;
	end

	// scan step: a second match must wait until the pending one can go out
	assign stall    = chk_valid_q && chk_match && pend_valid_q && !out_free;
	assign adv      = cmd.scan_run && !stall;
	assign take     = adv && chk_valid_q && chk_match;
	assign push_mid = take && pend_valid_q;
	assign issue    = adv && (7'(rd_ptr_q) < cnt7);

	assign rd_en   = cmd.rd_entry || issue;
	assign rd_addr = cmd.rd_entry ? req_q.entry_index[IW-1:0] : rd_ptr_q[IW-1:0];
	assign wr_addr = req_q.entry_index[IW-1:0];

	// read-modify-write of one row; a new entry starts from cleared values
	assign create   = (idx7 == cnt7);
	assign atom_bit = NA'(64'(1) << req_q.atom_index);
	assign sat_cost = (req_q.new_cost > COST_MAX) ? CSW'(COST_MAX) : CSW'(req_q.new_cost);

	always_comb begin
		if (create) begin
			new_pre_v   = '0;
			new_pre_dc  = '1;
			new_post_v  = '0;
			new_post_dc = '1;
			new_cost    = CSW'(1);
		end else begin
			new_pre_v   = rd_pre_v_q;
			new_pre_dc  = rd_pre_dc_q;
			new_post_v  = rd_post_v_q;
			new_post_dc = rd_post_dc_q;
			new_cost    = rd_cost_q;
		end
		priority if (req_q.action == ACT_SET_COST) begin
			new_cost = sat_cost;
		end else if (req_q.action == ACT_SET_PRE) begin
			new_pre_v  = req_q.atom_value ? (new_pre_v | atom_bit) : (new_pre_v & ~atom_bit);
			new_pre_dc = new_pre_dc & ~atom_bit;
		end else begin
			new_post_v  = req_q.atom_value ? (new_post_v | atom_bit)
				: (new_post_v & ~atom_bit);
			new_post_dc = new_post_dc & ~atom_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_entry) begin
			pre_v_mem[wr_addr]   <= new_pre_v;
			pre_dc_mem[wr_addr]  <= new_pre_dc;
			post_v_mem[wr_addr]  <= new_post_v;
			post_dc_mem[wr_addr] <= new_post_dc;
			cost_mem[wr_addr]    <= new_cost;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_pre_v_q   <= pre_v_mem[rd_addr];
			rd_pre_dc_q  <= pre_dc_mem[rd_addr];
			rd_post_v_q  <= post_v_mem[rd_addr];
			rd_post_dc_q <= post_dc_mem[rd_addr];
			rd_cost_q    <= cost_mem[rd_addr];
		end
	end

	// next result register contents
	always_comb begin
		priority if (push_mid) begin
			res_d = pend_q;
		end else if (cmd.emit_final && pend_valid_q) begin
			res_d      = pend_q;
			res_d.last = 1'b1;
		end else if (cmd.emit_final) begin
			res_d        = '0;
			res_d.status = ST_NONE;
			res_d.last   = 1'b1;
		end else if (cmd.emit_code) begin
			res_d        = '0;
			res_d.status = cmd.code;
			res_d.last   = 1'b1;
		end else begin
			res_d = res_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
		end
		if (issue) begin
			chk_idx_q <= rd_ptr_q[IW-1:0];
		end
		if (take) begin
			pend_q <= found;
		end
		res_q <= res_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			rd_ptr_q     <= '0;
			chk_valid_q  <= 1'b0;
			n_q          <= '0;
			lim_q        <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear_tab) begin
				count_q <= '0;
			end else if (cmd.wr_entry && create) begin
				count_q <= CW'(count_q + 1'b1);
			end
			if (cmd.capture) begin
				lim_q <= lim_in;
			end
			if (cmd.scan_start) begin
				rd_ptr_q     <= '0;
				chk_valid_q  <= 1'b0;
				n_q          <= '0;
				pend_valid_q <= 1'b0;
			end else if (adv) begin
				chk_valid_q <= issue;
				if (issue) begin
					rd_ptr_q <= CW'(rd_ptr_q + 1'b1);
				end
				if (take) begin
					pend_valid_q <= 1'b1;
					n_q          <= 7'(n_q + 1'b1);
				end
			end
			if (push_mid || cmd.emit_final || cmd.emit_code) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign result    = res_q;

endmodule

// ===== src/goal_action_transition_matcher_core.sv =====
// Goal action transition matcher.
// Request channel (req_valid/req_ready/request) carries clear, condition-write,
// cost-write and expand requests; result channel (res_valid/res_ready/result)
// returns one result per write, clear or rejected request and one or more per
// expand, the final one marked by last.
// A request is taken only while the block is idle; a write answers after the
// decode, read-modify-write and response states, a clear or a rejected request
// after decode and response, and the block is idle again as the answer enters
// the output register. An expand reads the action table memory one entry per
// cycle, while the scan is not stalled, through its single read port; the scan
// ends at the end of the table or once the result limit is reached.
// Results sit in a single output register: a stalled receiver holds the
// register and, once a second match is pending, freezes the table scan; no
// result is dropped or repeated. The next request can be accepted while the
// final result still waits in the output register.
// Reset empties the table at once (entry count to zero); new entries start
// from cleared conditions and cost 1, so no clearing pass is needed.
// Depends on gatm_pkg, gatm_ctrl and gatm_datapath.
module goal_action_transition_matcher_core import gatm_pkg::*; #(
	parameter int NUM_ENTRIES = 64,
	parameter int NUM_ATOMS   = 64,
	parameter int COST_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  gatm_req_t request,
	output logic      res_valid,
	input  logic      res_ready,
	output gatm_rsp_t result
);

	gatm_cmd_t  cmd;
	gatm_stat_t stat;

	gatm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gatm_datapath #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.NUM_ATOMS   (NUM_ATOMS),
		.COST_BITS   (COST_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.result    (result)
	);

endmodule
